// ----- rtl/uvs_pkg.sv -----
`default_nettype none
package uvs_pkg;

    // long-division chains: 43 dividend bits, divisor is twice a segment count
    localparam int unsigned DIV_BITS = 43;
    localparam int unsigned DIV_W    = 9;

    localparam int unsigned CORDIC_ITERS = 24;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

    // atan(2^-i) in 1/2^32 turn
    localparam logic [31:0] ATAN_TURN32 [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_RADIUS      = 3'd0;
    localparam logic [2:0] REG_PHI_BEGIN   = 3'd1;
    localparam logic [2:0] REG_PHI_SPAN    = 3'd2;
    localparam logic [2:0] REG_THETA_BEGIN = 3'd3;
    localparam logic [2:0] REG_THETA_SPAN  = 3'd4;
    localparam logic [2:0] REG_WIDTH_SEG   = 3'd5;
    localparam logic [2:0] REG_HEIGHT_SEG  = 3'd6;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } cordic_t;

    typedef struct packed {
        logic [15:0] vertex_index;
        logic        upper_tri;
        logic        lower_tri;
        logic        in_grid;
    } side_t;

    typedef struct packed {
        logic signed [15:0] tex_u;
        logic [14:0]        tex_v;
    } tex_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        tex_t               tex;
        side_t              side;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/uv_sphere_vertex_generator.sv -----
// UV-sphere vertex generator.
// Input stream: one beat per grid point, s_tdata = {row, column}. Output stream:
// one beat per input beat, in order, carrying position, normal, texture
// coordinates and vertex number in m_tdata and the triangle/grid flags in m_tuser.
// Sphere geometry sits in seven APB registers (radius, angle begin/span,
// segment counts); write them only while no beat is in flight.
// Throughput: one beat per cycle while the receiver does not stall the output.
// The path is chains of 43 long-division cells (angle steps
// and texture coordinates), a 24-cell CORDIC for each angle, a fold-undo stage and
// the multiply/round and saturation stages.
// The output has a register plus a one-entry skid. While the receiver stalls
// the pipeline keeps going until the skid fills; then s_tready drops and the
// whole chain holds its contents.
// Reset empties the pipeline and loads the default sphere: radius 1.0, full
// azimuth, half-turn polar sweep, 32 x 16 segments.
`default_nettype none
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 255,
    parameter int unsigned ANGLE_BITS   = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // column[7:0], row[15:8]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u (16 each), tex_v (15),
    // vertex_index (16), zero pad
    output logic      [143:0] m_tdata,
    output logic      [2:0]   m_tuser    // upper_tri, lower_tri, in_grid
);

    localparam int unsigned LAT      = 73;
    localparam int unsigned SIDE_LEN = 71;   // stages 1..71
    localparam int unsigned TEX_LEN  = 28;   // stages 44..71
    localparam logic [9:0]  MAX_SEG  = 10'(MAX_SEGMENTS);
    localparam logic [31:0] ANG_HALF = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // ---------------- configuration ----------------
    logic signed [15:0] radius_reg;
    logic [15:0]        phi_begin_reg;
    logic [16:0]        phi_span_reg;
    logic [15:0]        theta_begin_reg;
    logic [15:0]        theta_span_reg;
    logic [7:0]         wseg_reg;
    logic [7:0]         hseg_reg;
    logic [2:0]         reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= 16'sd256;
            phi_begin_reg   <= 16'd0;
            phi_span_reg    <= 17'd65536;
            theta_begin_reg <= 16'd0;
            theta_span_reg  <= 16'd32768;
            wseg_reg        <= 8'd32;
            hseg_reg        <= 8'd16;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                REG_RADIUS:      radius_reg      <= pwdata[15:0];
                REG_PHI_BEGIN:   phi_begin_reg   <= pwdata[15:0];
                REG_PHI_SPAN:    phi_span_reg    <= pwdata[16:0];
                REG_THETA_BEGIN: theta_begin_reg <= pwdata[15:0];
                REG_THETA_SPAN:  theta_span_reg  <= pwdata[15:0];
                REG_WIDTH_SEG:   wseg_reg        <= pwdata[7:0];
                REG_HEIGHT_SEG:  hseg_reg        <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RADIUS:      prdata = {16'd0, radius_reg};
            REG_PHI_BEGIN:   prdata = {16'd0, phi_begin_reg};
            REG_PHI_SPAN:    prdata = {15'd0, phi_span_reg};
            REG_THETA_BEGIN: prdata = {16'd0, theta_begin_reg};
            REG_THETA_SPAN:  prdata = {16'd0, theta_span_reg};
            REG_WIDTH_SEG:   prdata = {24'd0, wseg_reg};
            REG_HEIGHT_SEG:  prdata = {24'd0, hseg_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // effective segment counts and pole closure
    logic [7:0] w_lo, h_lo, w_eff, h_eff;
    logic       open_top, closed_bottom;

    always_comb
    begin
        w_lo  = (wseg_reg < 8'd3) ? 8'd3 : wseg_reg;
        h_lo  = (hseg_reg < 8'd2) ? 8'd2 : hseg_reg;
        w_eff = ({2'b00, w_lo} > MAX_SEG) ? MAX_SEG[7:0] : w_lo;
        h_eff = ({2'b00, h_lo} > MAX_SEG) ? MAX_SEG[7:0] : h_lo;
        open_top      = theta_begin_reg != 16'd0;
        closed_bottom = ({1'b0, theta_begin_reg} + {1'b0, theta_span_reg}) >= 17'd32768;
    end

    // ---------------- flow control ----------------
    logic    en;
    logic    vld_reg [LAT];
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, skid_data_reg, m3_reg;
    logic    load_out_pipe, load_out_skid, load_skid;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- stage 0: input ----------------
    logic [7:0] col_reg, row_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= s_tdata[7:0];
            row_reg <= s_tdata[15:8];
        end
    end

    logic [24:0]         phi_prod;
    logic [23:0]         th_prod;
    logic                so_pos, so_neg;
    logic [25:0]         u_num;
    logic [7:0]          h_minus_row;
    logic [22:0]         v_num;
    logic [DIV_BITS-1:0] phi_dvd, th_dvd, u_dvd, v_dvd;
    logic [DIV_W-1:0]    d_w, d_h;
    logic [16:0]         vi_full;
    logic                quad;
    side_t               side0;

    always_comb
    begin
        phi_prod = 25'(col_reg) * 25'(phi_span_reg);
        th_prod  = 24'(row_reg) * 24'(theta_span_reg);
        phi_dvd  = 43'({phi_prod, 17'd0}) + 43'(w_eff);
        th_dvd   = 43'({th_prod, 17'd0}) + 43'(h_eff);

        so_pos = (row_reg == 8'd0) && !open_top;
        so_neg = !so_pos && (row_reg == h_eff) && closed_bottom;
        u_num  = 26'({col_reg, 15'd0}) + 26'(w_eff) * 26'd32769;
        if (so_pos)
        begin
            u_num = u_num + 26'd16384;
        end
        else if (so_neg)
        begin
            u_num = u_num - 26'd16384;
        end
        u_dvd = 43'(u_num);

        h_minus_row = h_eff - row_reg;
        v_num = (row_reg < h_eff) ? (23'({h_minus_row, 15'd0}) + 23'(h_eff)) : 23'd0;
        v_dvd = 43'(v_num);

        d_w = {w_eff, 1'b0};
        d_h = {h_eff, 1'b0};

        vi_full = 17'(row_reg) * (17'(w_eff) + 17'd1) + 17'(col_reg);
        quad    = (col_reg < w_eff) && (row_reg < h_eff);
        side0.vertex_index = vi_full[16] ? 16'hFFFF : vi_full[15:0];
        side0.upper_tri    = quad && ((row_reg != 8'd0) || open_top);
        side0.lower_tri    = quad && ((row_reg != (h_eff - 8'd1)) || !closed_bottom);
        side0.in_grid      = (col_reg <= w_eff) && (row_reg <= h_eff);
    end

    // ---------------- stages 1..43: division cells ----------------
    logic [DIV_W-1:0]    phi_rem [DIV_BITS+1];
    logic [DIV_W-1:0]    th_rem  [DIV_BITS+1];
    logic [DIV_W-1:0]    u_rem   [DIV_BITS+1];
    logic [DIV_W-1:0]    v_rem   [DIV_BITS+1];
    logic [DIV_BITS-1:0] phi_word [DIV_BITS+1];
    logic [DIV_BITS-1:0] th_word  [DIV_BITS+1];
    logic [DIV_BITS-1:0] u_word   [DIV_BITS+1];
    logic [DIV_BITS-1:0] v_word   [DIV_BITS+1];

    assign phi_rem[0]  = '0;
    assign th_rem[0]   = '0;
    assign u_rem[0]    = '0;
    assign v_rem[0]    = '0;
    assign phi_word[0] = phi_dvd;
    assign th_word[0]  = th_dvd;
    assign u_word[0]   = u_dvd;
    assign v_word[0]   = v_dvd;

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        uvs_div_cell u_phi (
            .clk(clk), .en(en), .divisor(d_w),
            .rem_in(phi_rem[k]), .word_in(phi_word[k]),
            .rem_out(phi_rem[k+1]), .word_out(phi_word[k+1])
        );
        uvs_div_cell u_th (
            .clk(clk), .en(en), .divisor(d_h),
            .rem_in(th_rem[k]), .word_in(th_word[k]),
            .rem_out(th_rem[k+1]), .word_out(th_word[k+1])
        );
        uvs_div_cell u_u (
            .clk(clk), .en(en), .divisor(d_w),
            .rem_in(u_rem[k]), .word_in(u_word[k]),
            .rem_out(u_rem[k+1]), .word_out(u_word[k+1])
        );
        uvs_div_cell u_v (
            .clk(clk), .en(en), .divisor(d_h),
            .rem_in(v_rem[k]), .word_in(v_word[k]),
            .rem_out(v_rem[k+1]), .word_out(v_word[k+1])
        );
    end

    side_t side_reg [SIDE_LEN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            for (int i = 1; i < SIDE_LEN; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- stage 44: angle rounding, quadrant fold ----------------
    function automatic cordic_t angle_init(input logic [15:0] ang_begin,
                                           input logic [31:0] step);
        logic [31:0] a32;
        logic [31:0] zf;
        logic        fold;
        a32  = ({ang_begin, 16'd0} + step + ANG_HALF) & ANG_MASK;
        fold = a32[31] ^ a32[30];
        zf   = {a32[31] ^ fold, a32[30:0]};
        angle_init.x   = $signed({2'b00, CORDIC_GAIN});
        angle_init.y   = 34'sd0;
        angle_init.z   = $signed({zf[31], zf[31], zf});
        angle_init.neg = fold;
        return angle_init;
    endfunction

    cordic_t phi_c [CORDIC_ITERS+1];
    cordic_t th_c  [CORDIC_ITERS+1];
    cordic_t phi_init_reg, th_init_reg;
    tex_t    tex0;
    tex_t    tex_reg [TEX_LEN];

    always_comb
    begin
        if (u_word[DIV_BITS] > 43'd49151)
        begin
            tex0.tex_u = 16'sd32767;
        end
        else
        begin
            tex0.tex_u = u_word[DIV_BITS][15:0] - 16'd16384;
        end
        tex0.tex_v = v_word[DIV_BITS][14:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_init_reg <= angle_init(phi_begin_reg, phi_word[DIV_BITS][31:0]);
            th_init_reg  <= angle_init(theta_begin_reg, th_word[DIV_BITS][31:0]);
            tex_reg[0]   <= tex0;
            for (int i = 1; i < TEX_LEN; i++)
            begin
                tex_reg[i] <= tex_reg[i-1];
            end
        end
    end

    // ---------------- stages 45..68: CORDIC cells ----------------
    assign phi_c[0] = phi_init_reg;
    assign th_c[0]  = th_init_reg;

    for (genvar k = 0; k < CORDIC_ITERS; k++)
    begin : g_cordic
        uvs_cordic_cell #(.STAGE(k)) u_phi (
            .clk(clk), .en(en), .din(phi_c[k]), .dout(phi_c[k+1])
        );
        uvs_cordic_cell #(.STAGE(k)) u_th (
            .clk(clk), .en(en), .din(th_c[k]), .dout(th_c[k+1])
        );
    end

    // ---------------- stage 69: undo fold ----------------
    logic signed [33:0] cpn, spn, ctn, stn;
    logic signed [31:0] cp_reg, sp_reg, ct_reg, st_reg;

    always_comb
    begin
        cpn = phi_c[CORDIC_ITERS].neg ? -phi_c[CORDIC_ITERS].x : phi_c[CORDIC_ITERS].x;
        spn = phi_c[CORDIC_ITERS].neg ? -phi_c[CORDIC_ITERS].y : phi_c[CORDIC_ITERS].y;
        ctn = th_c[CORDIC_ITERS].neg ? -th_c[CORDIC_ITERS].x : th_c[CORDIC_ITERS].x;
        stn = th_c[CORDIC_ITERS].neg ? -th_c[CORDIC_ITERS].y : th_c[CORDIC_ITERS].y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg <= cpn[31:0];
            sp_reg <= spn[31:0];
            ct_reg <= ctn[31:0];
            st_reg <= stn[31:0];
        end
    end

    // ---------------- stage 70: radius products ----------------
    logic               sg_pos, sg_neg;
    logic signed [47:0] rcp, rsp, rct;
    logic signed [48:0] axt, azt, pyt;
    logic signed [32:0] ctv, nyt;
    logic signed [63:0] cst, spst;

    logic signed [31:0] ax_reg, az_reg, st_m1_reg;
    logic signed [17:0] py_raw_reg;
    logic signed [16:0] ny_raw_reg;
    logic signed [63:0] cst_reg, spst_reg;
    logic               sg_pos_reg, sg_neg_reg;

    always_comb
    begin
        sg_pos = radius_reg > 16'sd0;
        sg_neg = radius_reg < 16'sd0;
        rcp  = radius_reg * cp_reg;
        rsp  = radius_reg * sp_reg;
        rct  = radius_reg * ct_reg;
        axt  = 49'sd16384 - rcp;
        azt  = rsp + 49'sd16384;
        pyt  = rct + 49'sd536870912;
        cst  = cp_reg * st_reg;
        spst = sp_reg * st_reg;
        ctv  = sg_pos ? ct_reg : (sg_neg ? -ct_reg : 33'sd0);
        nyt  = ctv + 33'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= axt[46:15];
            az_reg     <= azt[46:15];
            py_raw_reg <= pyt[47:30];
            ny_raw_reg <= nyt[32:16];
            cst_reg    <= cst;
            spst_reg   <= spst;
            st_m1_reg  <= st_reg;
            sg_pos_reg <= sg_pos;
            sg_neg_reg <= sg_neg;
        end
    end

    // ---------------- stage 71: second products ----------------
    logic signed [63:0] pxp, pzp;
    logic signed [64:0] pxt, pzt, nxv, nzv, nxt, nzt;

    logic signed [19:0] px_raw_reg, pz_raw_reg, py2_reg;
    logic signed [18:0] nx_raw_reg, nz_raw_reg, ny2_reg;

    always_comb
    begin
        pxp = ax_reg * st_m1_reg;
        pzp = az_reg * st_m1_reg;
        pxt = pxp + 65'sd17592186044416;
        pzt = pzp + 65'sd17592186044416;
        nxv = sg_pos_reg ? -cst_reg : (sg_neg_reg ? cst_reg : 65'sd0);
        nzv = sg_pos_reg ? spst_reg : (sg_neg_reg ? -spst_reg : 65'sd0);
        nxt = nxv + 65'sd35184372088832;
        nzt = nzv + 65'sd35184372088832;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_raw_reg <= pxt[64:45];
            pz_raw_reg <= pzt[64:45];
            py2_reg    <= {{2{py_raw_reg[17]}}, py_raw_reg};
            nx_raw_reg <= nxt[64:46];
            nz_raw_reg <= nzt[64:46];
            ny2_reg    <= {{2{ny_raw_reg[16]}}, ny_raw_reg};
        end
    end

    // ---------------- stage 72: saturation, assembly ----------------
    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
        begin
            return 16'h7FFF;
        end
        else if (v < -20'sd32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] sat_norm(input logic signed [18:0] v);
        if (v > 19'sd16384)
        begin
            return 16'h4000;
        end
        else if (v < -19'sd16384)
        begin
            return 16'hC000;
        end
        return v[15:0];
    endfunction

    result_t m3_next;

    always_comb
    begin
        m3_next.pos_x  = sat16(px_raw_reg);
        m3_next.pos_y  = sat16(py2_reg);
        m3_next.pos_z  = sat16(pz_raw_reg);
        m3_next.norm_x = sat_norm(nx_raw_reg);
        m3_next.norm_y = sat_norm(ny2_reg);
        m3_next.norm_z = sat_norm(nz_raw_reg);
        m3_next.tex    = tex_reg[TEX_LEN-1];
        m3_next.side   = side_reg[SIDE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg <= m3_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_pipe   = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                load_out_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (vld_reg[LAT-1])
        begin
            if (!out_valid_reg || m_tready)
            begin
                load_out_pipe  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_pipe)
        begin
            out_data_reg <= m3_reg;
        end
        else if (load_out_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= m3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_data_reg.side.vertex_index,
                       out_data_reg.tex.tex_v,
                       out_data_reg.tex.tex_u,
                       out_data_reg.norm_z,
                       out_data_reg.norm_y,
                       out_data_reg.norm_x,
                       out_data_reg.pos_z,
                       out_data_reg.pos_y,
                       out_data_reg.pos_x};
    assign m_tuser  = {out_data_reg.side.in_grid,
                       out_data_reg.side.lower_tri,
                       out_data_reg.side.upper_tri};

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready && !skid_valid_reg && vld_reg[LAT-1] |=> skid_valid_reg)
        else $error("finished beat dropped during output stall");

    a_tri_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tuser[2])
        else $error("triangle flag set outside the grid");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg.norm_x <= 16'sd16384) && (out_data_reg.norm_x >= -16'sd16384)
                  && (out_data_reg.norm_z <= 16'sd16384) && (out_data_reg.norm_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule
`default_nettype wire

// ----- rtl/uvs_div_cell.sv -----
`default_nettype none
module uvs_div_cell
    import uvs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [DIV_W-1:0]    divisor,
    input  wire logic [DIV_W-1:0]    rem_in,
    input  wire logic [DIV_BITS-1:0] word_in,
    output logic      [DIV_W-1:0]    rem_out,
    output logic      [DIV_BITS-1:0] word_out
);

    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_BITS-1:0] word_reg, word_next;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                ge;

    // one restoring step: dividend bits leave at the top, quotient bits enter at the bottom
    always_comb
    begin
        trial     = {rem_in, word_in[DIV_BITS-1]};
        diff      = trial - {1'b0, divisor};
        ge        = trial >= {1'b0, divisor};
        rem_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        word_next = {word_in[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
        end
    end

    assign rem_out  = rem_reg;
    assign word_out = word_reg;

endmodule
`default_nettype wire

// ----- rtl/uvs_cordic_cell.sv -----
`default_nettype none
module uvs_cordic_cell
    import uvs_pkg::*;
#(
    parameter int unsigned STAGE = 0
)
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire cordic_t din,
    output cordic_t      dout
);

    cordic_t            st_reg, st_next;
    logic signed [33:0] dx, dy, ang;

    always_comb
    begin
        dx  = din.x >>> STAGE;
        dy  = din.y >>> STAGE;
        ang = $signed({2'b00, ATAN_TURN32[STAGE]});
        st_next.neg = din.neg;
        if (din.z >= 0)
        begin
            st_next.x = din.x - dy;
            st_next.y = din.y + dx;
            st_next.z = din.z - ang;
        end
        else
        begin
            st_next.x = din.x + dy;
            st_next.y = din.y - dx;
            st_next.z = din.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign dout = st_reg;

endmodule
`default_nettype wire

// ----- sim/tb_uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
module tb_uv_sphere_vertex_generator;
    import uvs_pkg::*;

    typedef struct {
        logic [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u;
        logic [14:0] tex_v;
        logic [15:0] vertex_index;
        logic        upper_tri, lower_tri, in_grid;
    } vertex_t;

    class vertex_scoreboard;
        longint   radius;
        longint   phi_begin, phi_span, theta_begin, theta_span, wseg, hseg;
        vertex_t  pending[$];
        int       errors;

        function new();
            radius = 256; phi_begin = 0; phi_span = 65536; theta_begin = 0;
            theta_span = 32768; wseg = 32; hseg = 16; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_RADIUS:      radius = longint'($signed(v[15:0]));
                REG_PHI_BEGIN:   phi_begin = longint'(v[15:0]);
                REG_PHI_SPAN:    phi_span = longint'(v[16:0]);
                REG_THETA_BEGIN: theta_begin = longint'(v[15:0]);
                REG_THETA_SPAN:  theta_span = longint'(v[15:0]);
                REG_WIDTH_SEG:   wseg = longint'(v[7:0]);
                REG_HEIGHT_SEG:  hseg = longint'(v[7:0]);
                default: ;
            endcase
        endfunction

        function longint eff_w();
            return wseg < 3 ? 3 : wseg;
        endfunction

        function longint eff_h();
            return hseg < 2 ? 2 : hseg;
        endfunction

        static function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function logic [15:0] step_angle(longint b, longint span, longint i, longint n);
            longint unsigned num, stp, a32;
            num = longint'(i) * span * 65536;
            stp = (2 * num + n) / (2 * n);
            a32 = b * 65536 + stp;
            return 16'((a32 + (64'd1 << 15)) >> 16);
        endfunction

        // rotation CORDIC, Q30 outputs; angles in the left half are folded by pi
        static function void sincos(logic [15:0] a, output longint c, output longint s);
            logic [31:0] z32;
            bit          flip;
            longint      x, y, z, dx, dy;
            z32 = {a, 16'd0};
            flip = 0;
            if (z32 >= 32'h4000_0000 && z32 < 32'hC000_0000)
            begin
                z32 = z32 - 32'h8000_0000;
                flip = 1;
            end
            z = longint'($signed(z32));
            x = longint'(CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < CORDIC_ITERS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(ATAN_TURN32[i]);
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(ATAN_TURN32[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_point(logic [7:0] col, logic [7:0] row);
            vertex_t e;
            longint  w, h, cp, sp, ct, st, sg, so, num, tv, vi;
            bit      open_top, closed_bot, quad;
            w = eff_w();
            h = eff_h();
            open_top = theta_begin > 0;
            closed_bot = theta_begin + theta_span >= 32768;
            sincos(step_angle(phi_begin, phi_span, col, w), cp, sp);
            sincos(step_angle(theta_begin, theta_span, row, h), ct, st);
            e.pos_x = 16'(clip(rnd(rnd(-radius * cp, 15) * st, 45), -32768, 32767));
            e.pos_y = 16'(clip(rnd(radius * ct, 30), -32768, 32767));
            e.pos_z = 16'(clip(rnd(rnd(radius * sp, 15) * st, 45), -32768, 32767));
            sg = radius > 0 ? 1 : (radius < 0 ? -1 : 0);
            e.norm_x = 16'(clip(rnd(-sg * cp * st, 46), -16384, 16384));
            e.norm_y = 16'(clip(rnd(sg * ct, 16), -16384, 16384));
            e.norm_z = 16'(clip(rnd(sg * sp * st, 46), -16384, 16384));
            so = 0;
            if (row == 0 && !open_top)
                so = 1;
            else if (row == h && closed_bot)
                so = -1;
            num = (2 * longint'(col) + so) * 16384 + w + 32768 * w;
            e.tex_u = 16'(clip(num / (2 * w) - 16384, -32768, 32767));
            tv = row < h ? ((h - row) * 32768 + h) / (2 * h) : 0;
            e.tex_v = 15'(clip(tv, 0, 32767));
            vi = longint'(row) * (w + 1) + col;
            e.vertex_index = 16'(vi > 65535 ? 65535 : vi);
            quad = col < w && row < h;
            e.upper_tri = quad && (row != 0 || open_top);
            e.lower_tri = quad && (row != h - 1 || !closed_bot);
            e.in_grid = col <= w && row <= h;
            pending = {pending, e};
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_vertex(logic [143:0] d, logic [2:0] u);
            vertex_t e;
            if (pending.size() == 0)
            begin
                $error("output beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("pos_x", e.pos_x, d[15:0]);
            cmp("pos_y", e.pos_y, d[31:16]);
            cmp("pos_z", e.pos_z, d[47:32]);
            cmp("norm_x", e.norm_x, d[63:48]);
            cmp("norm_y", e.norm_y, d[79:64]);
            cmp("norm_z", e.norm_z, d[95:80]);
            cmp("tex_u", e.tex_u, d[111:96]);
            cmp("tex_v", e.tex_v, d[126:112]);
            cmp("vertex_index", e.vertex_index, d[142:127]);
            cmp("upper_tri", e.upper_tri, u[0]);
            cmp("lower_tri", e.lower_tri, u[1]);
            cmp("in_grid", e.in_grid, u[2]);
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    logic [2:0]   m_tuser;

    int tx_idle = 0;
    int rx_idle = 0;
    int stall_left = 0;
    bit stall_req = 0;

    vertex_scoreboard sb = new();

    uv_sphere_vertex_generator dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (stall_req)
        begin
            stall_req = 0;
            stall_left = 400;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_point(s_tdata[7:0], s_tdata[15:8]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_vertex(m_tdata, m_tuser);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic send_point(logic [7:0] col, logic [7:0] row);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {row, col};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic load_sphere(logic [15:0] r, logic [15:0] pb, logic [16:0] ps,
                               logic [15:0] tb, logic [15:0] ts, logic [7:0] ws,
                               logic [7:0] hs);
        write_reg(REG_RADIUS, {16'd0, r});
        write_reg(REG_PHI_BEGIN, {16'd0, pb});
        write_reg(REG_PHI_SPAN, {15'd0, ps});
        write_reg(REG_THETA_BEGIN, {16'd0, tb});
        write_reg(REG_THETA_SPAN, {16'd0, ts});
        write_reg(REG_WIDTH_SEG, {24'd0, ws});
        write_reg(REG_HEIGHT_SEG, {24'd0, hs});
    endtask

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int w, h;
        logic [7:0] c, r;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // default sphere: poles, seam, grid edges and far outside
        send_point(0, 0);
        send_point(1, 0);
        send_point(32, 16);
        send_point(0, 16);
        send_point(31, 15);
        send_point(31, 14);
        send_point(16, 8);
        send_point(33, 5);
        send_point(5, 17);
        send_point(255, 255);
        send_point(8'hAA, 8'h55);
        send_point(8'h55, 8'hAA);
        drain();
        load_sphere(16'h0000, 16'h4000, 17'h08000, 16'h2000, 16'h4000, 8'd1, 8'd1);
        send_point(0, 0);
        send_point(3, 2);
        send_point(2, 1);
        send_point(4, 3);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            tx_idle = p < 3 ? 38 : (p < 6 ? 49 : 0);
            rx_idle = p < 3 ? 49 : (p < 6 ? 38 : 0);
            if (p == 0)
                load_sphere(16'h7FFF, 16'hFFFF, 17'h1FFFF, 16'h0000, 16'hFFFF, 8'd0, 8'd0);
            else if (p == 1)
                load_sphere(16'h8000, 16'h0000, 17'h00000, 16'hFFFF, 16'h0000,
                            8'd255, 8'd255);
            else if (p == 2)
                load_sphere(16'h0000, 16'($urandom), 17'($urandom), 16'h0000, 16'h8000,
                            8'($urandom_range(40)), 8'($urandom_range(40)));
            else
                load_sphere(16'($urandom), 16'($urandom),
                            $urandom_range(1) ? 17'h10000 : 17'($urandom),
                            $urandom_range(1) ? 16'($urandom_range(32768)) : 16'($urandom),
                            $urandom_range(1) ? 16'($urandom_range(32768)) : 16'($urandom),
                            8'($urandom_range(40)), 8'($urandom_range(40)));
            w = int'(sb.eff_w());
            h = int'(sb.eff_h());
            for (int i = 0; i < 185; i++)
            begin
                if (p == 4 && i == 60)
                    stall_req = 1;
                if ($urandom_range(99) < 80)
                begin
                    c = 8'($urandom_range(w + 1 > 255 ? 255 : w + 1));
                    r = 8'($urandom_range(h + 1 > 255 ? 255 : h + 1));
                end
                else
                begin
                    c = 8'($urandom);
                    r = 8'($urandom);
                end
                send_point(c, r);
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
